FILE: rtl/core/ols_pkg.sv
package ols_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TREE_N = 2 ** IDX_W;
    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int FIDX_W = 6;
    localparam int ECNT_W = 7;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_POP    = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_REMOVE = 3'd5,
        CMD_READ   = 3'd6,
        CMD_NOP    = 3'd7
    } cmd_e;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_e;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_PUSH,
        CM_INSERT,
        CM_DELETE,
        CM_COMPACT
    } cell_mode_e;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT
    } state_e;

    typedef struct packed {
        cmd_e                     command;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_e                  status;
        logic signed [WORD_W-1:0] data_out;
        logic [FIDX_W-1:0]        found_index;
        logic [ECNT_W-1:0]        entry_count;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
        logic [IDX_W-1:0]  rd_idx;
        logic [WORD_W-1:0] key;
    } cell_ctl_t;

    function automatic logic [DEPTH-1:0] idx_bit_mask(input int b);
        logic [DEPTH-1:0] m;
        for (int i = 0; i < DEPTH; i++) begin
            m[i] = ((i >> b) & 1) == 1;
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/ols_cell.sv
module ols_cell (
    input  logic                      aclk,
    input  logic [ols_pkg::IDX_W-1:0] cell_idx,
    input  ols_pkg::cell_ctl_t        ctl,
    input  ols_pkg::cell_mode_e       mode,
    input  logic                      compact_en,
    input  logic [ols_pkg::WORD_W-1:0] left_data,
    input  logic [ols_pkg::WORD_W-1:0] right_data,
    output logic [ols_pkg::WORD_W-1:0] data_out,
    output logic                      match,
    output logic [ols_pkg::WORD_W-1:0] rd_data
);
    import ols_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    int unsigned       idx_u;
    int unsigned       pos_u;
    int unsigned       cnt_u;

    assign idx_u = 32'(cell_idx);
    assign pos_u = 32'(ctl.pos);
    assign cnt_u = 32'(ctl.cnt);

    always_comb begin
        data_next = data_reg;
        case (mode)
            CM_PUSH: begin
                if (idx_u == cnt_u) data_next = ctl.key;
            end
            CM_INSERT: begin
                if (idx_u == pos_u) begin
                    data_next = ctl.key;
                end else if (idx_u > pos_u) begin
                    data_next = left_data;
                end
            end
            CM_DELETE: begin
                if (idx_u >= pos_u) data_next = right_data;
            end
            CM_COMPACT: begin
                if (compact_en) data_next = right_data;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign match    = (data_reg == ctl.key) && (idx_u < cnt_u);
    assign rd_data  = (cell_idx == ctl.rd_idx) ? data_reg : '0;

endmodule

FILE: rtl/core/ols_ctrl.sv
module ols_ctrl (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  ols_pkg::in_item_t                           s_item,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output ols_pkg::out_item_t                          m_item,
    output ols_pkg::cell_ctl_t                          ctl,
    output ols_pkg::cell_mode_e                         mode,
    output logic [ols_pkg::DEPTH-1:0]                   compact_mask,
    input  logic [ols_pkg::DEPTH-1:0]                   match,
    input  logic [ols_pkg::DEPTH-1:0][ols_pkg::WORD_W-1:0] rd_words
);
    import ols_pkg::*;

    state_e           state_reg, state_next;
    in_item_t         cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             removed_reg, removed_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_item_reg, m_item_next;
    out_item_t        res_reg, res_next;

    logic [DEPTH-1:0]               pm;
    logic [DEPTH-1:0]               first;
    logic [IDX_W-1:0]               fidx;
    logic                           any_match;
    logic [TREE_N-1:0][WORD_W-1:0]  words;
    logic [WORD_W-1:0]              rd_word;
    out_item_t                      res;
    logic                           finish;
    logic                           slot_free;
    int unsigned                    pos_u;
    int unsigned                    cnt_u;

    assign pos_u     = 32'(cmd_reg.position);
    assign cnt_u     = 32'(cnt_reg);
    assign any_match = |match;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        pm = match;
        for (int s = 0; s < IDX_W; s++) begin
            pm = pm | (pm << (2 ** s));
        end
        first = pm & ~(pm << 1);
        for (int b = 0; b < IDX_W; b++) begin
            fidx[b] = |(first & idx_bit_mask(b));
        end
    end

    always_comb begin
        words = '0;
        for (int i = 0; i < DEPTH; i++) begin
            words[i] = rd_words[i];
        end
        for (int l = 0; l < IDX_W; l++) begin
            for (int k = 0; k < (TREE_N >> (l + 1)); k++) begin
                words[k] = words[2 * k] | words[2 * k + 1];
            end
        end
        rd_word = words[0];
    end

    assign compact_mask = pm;

    always_comb begin
        ctl.pos    = cmd_reg.position;
        ctl.cnt    = cnt_reg;
        ctl.key    = cmd_reg.value;
        ctl.rd_idx = (cmd_reg.command == CMD_POP) ? IDX_W'(cnt_reg - CNT_W'(1))
                                                  : IDX_W'(cmd_reg.position);
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        removed_next = removed_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        res_next     = res_reg;
        finish       = 1'b0;
        mode         = CM_HOLD;

        res.status      = ST_OK;
        res.data_out    = '0;
        res.found_index = '0;
        res.entry_count = '0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_item;
                    removed_next = 1'b0;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                finish = 1'b1;
                case (cmd_reg.command)
                    CMD_PUSH: begin
                        if (cnt_u >= DEPTH) begin
                            res.status = ST_FULL;
                        end else begin
                            mode     = CM_PUSH;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (pos_u > cnt_u) begin
                            res.status = ST_RANGE;
                        end else if (cnt_u >= DEPTH) begin
                            res.status = ST_FULL;
                        end else begin
                            mode     = CM_INSERT;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    CMD_DELETE: begin
                        if (pos_u >= cnt_u) begin
                            res.status = ST_RANGE;
                        end else begin
                            mode     = CM_DELETE;
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end
                    CMD_POP: begin
                        if (cnt_u == 0) begin
                            res.status = ST_EMPTY;
                        end else begin
                            res.data_out = rd_word;
                            cnt_next     = cnt_reg - CNT_W'(1);
                        end
                    end
                    CMD_FIND: begin
                        if (any_match) begin
                            res.found_index = FIDX_W'(fidx);
                        end else begin
                            res.status = ST_NOTFOUND;
                        end
                    end
                    CMD_REMOVE: begin
                        if (any_match) begin
                            mode         = CM_COMPACT;
                            cnt_next     = cnt_reg - CNT_W'(1);
                            removed_next = 1'b1;
                            finish       = 1'b0;
                        end else if (!removed_reg) begin
                            res.status = ST_NOTFOUND;
                        end
                    end
                    CMD_READ: begin
                        if (pos_u >= cnt_u) begin
                            res.status = ST_RANGE;
                        end else begin
                            res.data_out = rd_word;
                        end
                    end
                    default: begin
                        res.status = ST_OK;
                    end
                endcase
                res.entry_count = ECNT_W'(cnt_next);
                if (finish) begin
                    if (slot_free) begin
                        m_item_next  = res;
                        m_valid_next = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        res_next   = res;
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (slot_free) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            removed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            removed_reg <= removed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_item_reg <= m_item_next;
        res_reg    <= res_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: rtl/core/ordered_list_store.sv
// Ordered list of up to 64 signed 32-bit words held in a row of cells.
// Input channel s_valid/s_ready/s_item carries one command item: push,
// insert, delete, pop, find, remove all, read. Result channel
// m_valid/m_ready/m_item returns one item per command with status,
// word read or popped, index found and entry count afterwards.
// Each cell holds one entry and talks to its two neighbors, so insert
// and delete shift the whole tail in parallel.
// The accepting edge loads the command register and enters S_EXEC;
// from there the result is registered into m_item and m_valid rises.
// New input items are taken only in S_IDLE; remove all repeats S_EXEC
// while matches remain, since each pass drops the first match and
// shifts the cells above it down by one.
// Reset (aresetn low at a clock edge) empties the list and drops any
// pending result; cell contents are not cleared and never read before
// being written.
// When m_ready is low the result stays in the output register; the
// next item is still taken and executed, then its result waits
// internally until the output register frees up.
module ordered_list_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ols_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ols_pkg::out_item_t  m_item
);
    import ols_pkg::*;

    cell_ctl_t                      ctl;
    cell_mode_e                     mode;
    logic [DEPTH-1:0]               compact_mask;
    logic [DEPTH-1:0]               match;
    logic [DEPTH-1:0][WORD_W-1:0]   rd_words;
    logic [DEPTH-1:0][WORD_W-1:0]   cell_data;

    ols_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .ctl          (ctl),
        .mode         (mode),
        .compact_mask (compact_mask),
        .match        (match),
        .rd_words     (rd_words)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        ols_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(i)),
            .ctl        (ctl),
            .mode       (mode),
            .compact_en (compact_mask[i]),
            .left_data  (left_w),
            .right_data (right_w),
            .data_out   (cell_data[i]),
            .match      (match[i]),
            .rd_data    (rd_words[i])
        );
    end

endmodule
